@@ hw/rtl/bmrf_pkg.sv @@
// shared types and codes for the bitmap rectangle fill and test block
package bmrf_pkg;

	// geometry of the coordinate path: signed Q11.4 inputs, widened for differences
	localparam int COORD_W = 16;
	localparam int DIFF_W  = 18;
	localparam int FRAC_W  = 4;

	// command codes
	localparam logic CMD_BURN = 1'b0;
	localparam logic CMD_TEST = 1'b1;

	// configuration register indexes
	localparam logic REG_CENTRE_X = 1'b0;
	localparam logic REG_CENTRE_Y = 1'b1;

	// per-item control registered when the item is accepted
	typedef struct packed {
		logic miss;
		logic test;
		logic value;
	} bmrf_ctl_t;

endpackage

@@ hw/rtl/bmrf_grid_mem.sv @@
// grid row memory: one write port, one registered read port
module bmrf_grid_mem #(
	parameter int GRID_W = 64,
	parameter int GRID_H = 64
) (
	input  logic                      clk,
	input  logic                      rd_en,
	input  logic [$clog2(GRID_H)-1:0] rd_addr,
	output logic [GRID_W-1:0]         rd_data_s1,
	input  logic                      wr_en,
	input  logic [$clog2(GRID_H)-1:0] wr_addr,
	input  logic [GRID_W-1:0]         wr_data
);

	logic [GRID_W-1:0] mem [GRID_H];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

endmodule

@@ hw/rtl/bmrf_rect_map.sv @@
// maps a world rectangle onto row bounds and a column mask of the grid
module bmrf_rect_map #(
	parameter int GRID_W = 64,
	parameter int GRID_H = 64
) (
	input  logic                            clk,
	input  logic                            load,
	input  logic                            command,
	input  logic                            value,
	input  logic signed [15:0]              min_x,
	input  logic signed [15:0]              min_y,
	input  logic signed [15:0]              max_x,
	input  logic signed [15:0]              max_y,
	input  logic signed [15:0]              centre_x,
	input  logic signed [15:0]              centre_y,
	output bmrf_pkg::bmrf_ctl_t             ctl_q,
	output logic [$clog2(GRID_H+1)-1:0]     y0_q,
	output logic [$clog2(GRID_H+1)-1:0]     y1_q,
	output logic [GRID_W-1:0]               mask_q
);

	import bmrf_pkg::*;

	localparam int CW     = $clog2(GRID_W + 1);
	localparam int RW     = $clog2(GRID_H + 1);
	localparam int HALF_W = GRID_W / 2;
	localparam int HALF_H = GRID_H / 2;

	localparam logic signed [DIFF_W-1:0] HW_S     = DIFF_W'(GRID_W * 8);
	localparam logic signed [DIFF_W-1:0] HH_S     = DIFF_W'(GRID_H * 8);
	localparam logic signed [DIFF_W-1:0] NEG_HW_S = DIFF_W'(-(GRID_W * 8));
	localparam logic signed [DIFF_W-1:0] NEG_HH_S = DIFF_W'(-(GRID_H * 8));
	localparam logic signed [DIFF_W-1:0] X_LO     = DIFF_W'(-HALF_W);
	localparam logic signed [DIFF_W-1:0] X_HI0    = DIFF_W'(HALF_W - 1);
	localparam logic signed [DIFF_W-1:0] X_HI1    = DIFF_W'(HALF_W);
	localparam logic signed [DIFF_W-1:0] Y_LO     = DIFF_W'(-HALF_H);
	localparam logic signed [DIFF_W-1:0] Y_HI0    = DIFF_W'(HALF_H - 1);
	localparam logic signed [DIFF_W-1:0] Y_HI1    = DIFF_W'(HALF_H);
	localparam logic signed [DIFF_W-1:0] X_OFS    = DIFF_W'(HALF_W);
	localparam logic signed [DIFF_W-1:0] Y_OFS    = DIFF_W'(HALF_H);
	localparam logic signed [DIFF_W-1:0] ROUND_UP = DIFF_W'((1 << FRAC_W) - 1);

	function automatic logic signed [DIFF_W-1:0] clampv(
		input logic signed [DIFF_W-1:0] v,
		input logic signed [DIFF_W-1:0] lo,
		input logic signed [DIFF_W-1:0] hi
	);
		logic signed [DIFF_W-1:0] r;
		r = v;
		if (v < lo) begin
			r = lo;
		end else if (v > hi) begin
			r = hi;
		end
		return r;
	endfunction

	logic signed [DIFF_W-1:0] dx0, dy0, dx1, dy1;
	logic signed [DIFF_W-1:0] rx1, ry1;
	logic signed [DIFF_W-1:0] fx0, fy0, cx1, cy1;
	logic signed [DIFF_W-1:0] sx0, sy0, sx1, sy1;
	logic [CW-1:0]            x0_c, x1_c;
	logic [RW-1:0]            y0_c, y1_c;
	logic                     miss_c;
	logic [GRID_W-1:0]        mask_c;

	// offsets from the map centre
	assign dx0 = {{2{min_x[15]}}, min_x} - {{2{centre_x[15]}}, centre_x};
	assign dy0 = {{2{min_y[15]}}, min_y} - {{2{centre_y[15]}}, centre_y};
	assign dx1 = {{2{max_x[15]}}, max_x} - {{2{centre_x[15]}}, centre_x};
	assign dy1 = {{2{max_y[15]}}, max_y} - {{2{centre_y[15]}}, centre_y};

	// strict overlap with the map
	assign miss_c = !(dx0 < HW_S && dx1 > NEG_HW_S && dy0 < HH_S && dy1 > NEG_HH_S);

	// floor of the min corner, ceil of the max corner
	assign rx1 = dx1 + ROUND_UP;
	assign ry1 = dy1 + ROUND_UP;
	assign fx0 = dx0 >>> FRAC_W;
	assign fy0 = dy0 >>> FRAC_W;
	assign cx1 = rx1 >>> FRAC_W;
	assign cy1 = ry1 >>> FRAC_W;

	assign sx0 = clampv(fx0, X_LO, X_HI0) + X_OFS;
	assign sx1 = clampv(cx1, X_LO, X_HI1) + X_OFS;
	assign sy0 = clampv(fy0, Y_LO, Y_HI0) + Y_OFS;
	assign sy1 = clampv(cy1, Y_LO, Y_HI1) + Y_OFS;

	assign x0_c = sx0[CW-1:0];
	assign x1_c = sx1[CW-1:0];
	assign y0_c = sy0[RW-1:0];
	assign y1_c = sy1[RW-1:0];

	always_comb begin
		for (int i = 0; i < GRID_W; i++) begin
			mask_c[i] = (CW'(i) >= x0_c) && (CW'(i) < x1_c);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ctl_q.miss  <= miss_c;
			ctl_q.test  <= (command == CMD_TEST);
			ctl_q.value <= value;
			y0_q        <= y0_c;
			y1_q        <= y1_c;
			mask_q      <= mask_c;
		end
	end

endmodule

@@ hw/rtl/bitmap_rect_fill_and_test_top.sv @@
// top level of the bitmap rectangle fill and test block
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+------------------------------------------
//  in       | in_valid / in_ready          | command, value, min_x, min_y, max_x, max_y
//  out      | out_valid / out_ready        | hit
//  cfg      | psel penable pwrite / pready | paddr, pwdata, prdata (centre_x, centre_y)
//
// an item is accepted only in the idle state; it then passes through setup, reads its
// grid rows in turn in the run state (at most GRID_H rows, none for a miss or an empty
// row span) and ends in the done state before the next item can be accepted; a burn does
// a masked read-modify-write per row and a test only reads, through the row memory
// after reset the block sweeps every row of the memory to zero with in_ready low
// a finished result sits in the output register; a stalled output holds the next result
// in the done state until the output register frees
module bitmap_rect_fill_and_test_top #(
	parameter int GRID_W = 64,
	parameter int GRID_H = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	// input item channel
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                command,
	input  logic                value,
	input  logic signed [15:0]  min_x,
	input  logic signed [15:0]  min_y,
	input  logic signed [15:0]  max_x,
	input  logic signed [15:0]  max_y,
	// result item channel
	output logic                out_valid,
	input  logic                out_ready,
	output logic                hit,
	// configuration port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	import bmrf_pkg::*;

	localparam int AW = $clog2(GRID_H);
	localparam int RW = $clog2(GRID_H + 1);

	// sequencer states
	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SETUP = 3'd2;
	localparam logic [2:0] ST_RUN   = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]               state_q;
	logic signed [15:0]       centre_x_q;
	logic signed [15:0]       centre_y_q;
	logic [RW-1:0]            row_q;
	logic                     rd_vld_s1;
	logic [AW-1:0]            row_s1;
	logic                     hit_acc_q;
	logic                     out_valid_q;
	logic                     hit_q;

	bmrf_ctl_t                ctl;
	logic [RW-1:0]            y0;
	logic [RW-1:0]            y1;
	logic [GRID_W-1:0]        mask;

	logic                     accept;
	logic                     rd_en;
	logic [GRID_W-1:0]        rd_data_s1;
	logic                     wr_en;
	logic [AW-1:0]            wr_addr;
	logic [GRID_W-1:0]        wr_data;
	logic [GRID_W-1:0]        match;
	logic                     can_load;
	logic                     cfg_wr;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centre_x_q <= '0;
			centre_y_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_CENTRE_X: centre_x_q <= pwdata[15:0];
				REG_CENTRE_Y: centre_y_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// reads return the register sign-extended to the bus
	always_comb begin
		case (paddr[2])
			REG_CENTRE_X: prdata = {{16{centre_x_q[15]}}, centre_x_q};
			REG_CENTRE_Y: prdata = {{16{centre_y_q[15]}}, centre_y_q};
			default:      prdata = '0;
		endcase
	end

	// ---------------- rectangle to grid mapping ----------------
	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	bmrf_rect_map #(
		.GRID_W(GRID_W),
		.GRID_H(GRID_H)
	) u_rect_map (
		.clk     (clk),
		.load    (accept),
		.command (command),
		.value   (value),
		.min_x   (min_x),
		.min_y   (min_y),
		.max_x   (max_x),
		.max_y   (max_y),
		.centre_x(centre_x_q),
		.centre_y(centre_y_q),
		.ctl_q   (ctl),
		.y0_q    (y0),
		.y1_q    (y1),
		.mask_q  (mask)
	);

	// ---------------- row engine ----------------
	// a row is read and written back the next cycle; the following row's read
	// overlaps that write, so a same-row collision cannot occur within an item
	assign rd_en = (state_q == ST_RUN) && !ctl.miss && (row_q < y1);

	// cells that equal the searched bit, inside the column span
	assign match = (ctl.value ? rd_data_s1 : ~rd_data_s1) & mask;

	always_comb begin
		if (state_q == ST_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = row_q[AW-1:0];
			wr_data = '0;
		end else begin
			wr_en   = rd_vld_s1 && !ctl.test;
			wr_addr = row_s1;
			wr_data = (rd_data_s1 & ~mask) | (ctl.value ? mask : '0);
		end
	end

	bmrf_grid_mem #(
		.GRID_W(GRID_W),
		.GRID_H(GRID_H)
	) u_grid_mem (
		.clk       (clk),
		.rd_en     (rd_en),
		.rd_addr   (row_q[AW-1:0]),
		.rd_data_s1(rd_data_s1),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	// ---------------- sequencer ----------------
	assign can_load = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			row_q     <= '0;
			rd_vld_s1 <= 1'b0;
			row_s1    <= '0;
			hit_acc_q <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			row_s1    <= row_q[AW-1:0];
			case (state_q)
				ST_CLEAR: begin
					// zero sweep over every row after reset
					if (row_q == RW'(GRID_H - 1)) begin
						state_q <= ST_IDLE;
					end
					row_q <= row_q + 1'b1;
				end
				ST_IDLE: begin
					if (accept) begin
						hit_acc_q <= 1'b0;
						state_q   <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					row_q   <= y0;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (rd_en) begin
						row_q <= row_q + 1'b1;
					end
					if (rd_vld_s1 && ctl.test && (|match)) begin
						hit_acc_q <= 1'b1;
					end
					// last write-back done and no read in flight
					if (!rd_en && !rd_vld_s1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (can_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && can_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && can_load) begin
			hit_q <= hit_acc_q && ctl.test;
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;

endmodule

@@ sim/testbench.sv @@
// self-checking testbench for the bitmap rectangle fill and test block
`timescale 1ns / 100ps

module testbench;
	import bmrf_pkg::*;

	localparam int GW          = 64;
	localparam int GH          = 64;
	localparam int HALF_W_Q    = GW * 8;   // half map width in q11.4 counts
	localparam int HALF_H_Q    = GH * 8;
	localparam int CYCLE_LIMIT = 600000;

	typedef struct packed {
		logic               command;
		logic               value;
		logic signed [15:0] min_x;
		logic signed [15:0] min_y;
		logic signed [15:0] max_x;
		logic signed [15:0] max_y;
	} rect_item_t;

	typedef enum int {SHAPE_INSIDE, SHAPE_NOISE, SHAPE_INVERTED, SHAPE_EDGE} rect_shape_t;

	// block ports, all that the bench drives known from time zero
	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               command  = CMD_BURN;
	logic               value    = 1'b0;
	logic signed [15:0] min_x    = '0;
	logic signed [15:0] min_y    = '0;
	logic signed [15:0] max_x    = '0;
	logic signed [15:0] max_y    = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               hit;
	logic               psel     = 1'b0;
	logic               penable  = 1'b0;
	logic               pwrite   = 1'b0;
	logic [2:0]         paddr    = '0;
	logic [31:0]        pwdata   = '0;
	logic [31:0]        prdata;
	logic               pready;

	// occupancy model and its configuration copy
	bit                 occupancy [GH][GW];
	logic signed [15:0] model_centre_x = '0;
	logic signed [15:0] model_centre_y = '0;

	rect_item_t pending_rects [$];
	logic       expected_hits [$];

	int  send_idle_pct  = 0;
	int  recv_stall_pct = 0;
	int  errors         = 0;
	int  cycles         = 0;
	int  items_accepted = 0;
	int  test_count     = 0;
	int  hit_count      = 0;
	int  off_map_count  = 0;
	int  centre_writes  = 0;
	logic exp_hit;

	bitmap_rect_fill_and_test_top #(
		.GRID_W(GW),
		.GRID_H(GH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.value(value),
		.min_x(min_x),
		.min_y(min_y),
		.max_x(max_x),
		.max_y(max_y),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.hit(hit),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #2 clk = ~clk;

	function automatic void report_failure(string what);
		errors++;
		if (errors <= 10) begin
			$display("error at cycle %0d: %s", cycles, what);
		end
	endfunction

	function automatic int clamp_int(int v, int lo, int hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// burns or tests one rectangle against the occupancy model, returns the expected hit
	function automatic logic apply_rect_to_grid(logic cmd, logic val, logic signed [15:0] ax0,
			logic signed [15:0] ay0, logic signed [15:0] ax1, logic signed [15:0] ay1);
		int   cx, cy, c0, c1, r0, r1;
		logic found;
		cx    = int'(model_centre_x);
		cy    = int'(model_centre_y);
		found = 1'b0;
		if (cmd == CMD_TEST) test_count++;
		// strict overlap, touching an edge is a miss
		if (!(int'(ax0) < cx + HALF_W_Q && int'(ax1) > cx - HALF_W_Q &&
				int'(ay0) < cy + HALF_H_Q && int'(ay1) > cy - HALF_H_Q)) begin
			off_map_count++;
			return 1'b0;
		end
		// min corner floored, max corner ceiled, in whole cells
		c0 = GW / 2 + clamp_int((int'(ax0) - cx) >>> 4, -GW / 2, GW / 2 - 1);
		r0 = GH / 2 + clamp_int((int'(ay0) - cy) >>> 4, -GH / 2, GH / 2 - 1);
		c1 = GW / 2 + clamp_int((int'(ax1) - cx + 15) >>> 4, -GW / 2, GW / 2);
		r1 = GH / 2 + clamp_int((int'(ay1) - cy + 15) >>> 4, -GH / 2, GH / 2);
		for (int r = r0; r < r1; r++) begin
			for (int c = c0; c < c1; c++) begin
				if (cmd == CMD_TEST) begin
					if (occupancy[r][c] == val) found = 1'b1;
				end else begin
					occupancy[r][c] = val;
				end
			end
		end
		if (cmd == CMD_TEST && found) hit_count++;
		return (cmd == CMD_TEST) ? found : 1'b0;
	endfunction

	function automatic void push_rect(logic cmd, logic val, int x0, int y0, int x1, int y1);
		rect_item_t r;
		r.command = cmd;
		r.value   = val;
		r.min_x   = 16'(x0);
		r.min_y   = 16'(y0);
		r.max_x   = 16'(x1);
		r.max_y   = 16'(y1);
		pending_rects.push_back(r);
	endfunction

	// mostly rectangles around the map with random content, some noise and broken ones
	function automatic rect_item_t random_rect();
		rect_item_t         r;
		rect_shape_t        shape;
		int                 roll, cx, cy, x0, y0, w, h, d;
		logic signed [15:0] tmp;
		roll = $urandom_range(99);
		if (roll < 70) shape = SHAPE_INSIDE;
		else if (roll < 82) shape = SHAPE_NOISE;
		else if (roll < 90) shape = SHAPE_INVERTED;
		else shape = SHAPE_EDGE;
		cx = int'(model_centre_x);
		cy = int'(model_centre_y);
		x0 = cx + int'($urandom_range(1120)) - 560;
		y0 = cy + int'($urandom_range(1120)) - 560;
		w  = ($urandom_range(9) == 0) ? int'($urandom_range(1100)) : int'($urandom_range(160));
		h  = ($urandom_range(9) == 0) ? int'($urandom_range(1100)) : int'($urandom_range(160));
		d  = int'($urandom_range(1));
		r.command = 1'($urandom_range(1));
		r.value   = 1'($urandom_range(1));
		r.min_x   = 16'(x0);
		r.min_y   = 16'(y0);
		r.max_x   = 16'(x0 + w);
		r.max_y   = 16'(y0 + h);
		case (shape)
			SHAPE_NOISE: begin
				r.min_x = 16'($urandom);
				r.min_y = 16'($urandom);
				r.max_x = 16'($urandom);
				r.max_y = 16'($urandom);
			end
			SHAPE_INVERTED: begin
				tmp     = r.min_x;
				r.min_x = r.max_x;
				r.max_x = tmp - 16'sd1;
			end
			SHAPE_EDGE: begin
				// touch a map edge exactly, or overlap it by one count
				case ($urandom_range(3))
					0: begin
						r.min_x = 16'(cx + HALF_W_Q - d);
						r.max_x = 16'(cx + HALF_W_Q + w);
					end
					1: begin
						r.max_x = 16'(cx - HALF_W_Q + d);
						r.min_x = 16'(cx - HALF_W_Q - w);
					end
					2: begin
						r.min_y = 16'(cy + HALF_H_Q - d);
						r.max_y = 16'(cy + HALF_H_Q + h);
					end
					default: begin
						r.max_y = 16'(cy - HALF_H_Q + d);
						r.min_y = 16'(cy - HALF_H_Q - h);
					end
				endcase
			end
			default: ;
		endcase
		return r;
	endfunction

	// sender: payload held until accepted, prediction taken at acceptance
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				expected_hits.push_back(apply_rect_to_grid(command, value, min_x, min_y,
						max_x, max_y));
				items_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (pending_rects.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					command  <= pending_rects[0].command;
					value    <= pending_rects[0].value;
					min_x    <= pending_rects[0].min_x;
					min_y    <= pending_rects[0].min_y;
					max_x    <= pending_rects[0].max_x;
					max_y    <= pending_rects[0].max_y;
					void'(pending_rects.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stalls, every result checked against the oldest expectation
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
			if (out_valid && out_ready) begin
				if (expected_hits.size() == 0) begin
					report_failure($sformatf("result hit=%0b with nothing expected", hit));
				end else begin
					exp_hit = expected_hits.pop_front();
					if (hit !== exp_hit) begin
						report_failure($sformatf("hit expected %0b actual %0b", exp_hit, hit));
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
					expected_hits.size());
			$display("status: fail");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_rects.size() != 0 || in_valid || expected_hits.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// apb write then read-back of one centre register, block idle
	task automatic configure_centre(logic reg_idx, logic signed [15:0] v);
		logic [31:0] readback;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_idx, 2'b00};
		pwdata  <= {{16{v[15]}}, v};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (reg_idx == REG_CENTRE_X) model_centre_x = v;
		else model_centre_y = v;
		centre_writes++;
		@(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		readback = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (readback[15:0] !== v) begin
			report_failure($sformatf("register %0d read expected %04h actual %04h",
					reg_idx, v, readback[15:0]));
		end
		@(negedge clk);
	endtask

	// random items in chunks, the sender pausing for the results after each chunk
	task automatic run_random(int send_pct, int recv_pct, int count);
		int left, chunk;
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		left = count;
		while (left > 0) begin
			chunk = $urandom_range(60, 30);
			if (chunk > left) chunk = left;
			repeat (chunk) pending_rects.push_back(random_rect());
			left -= chunk;
			wait_drained();
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part at the reset centre
		push_rect(CMD_TEST, 1'b0, -32768, -32768, 32767, 32767);  // empty map holds zeros
		push_rect(CMD_TEST, 1'b1, -32768, -32768, 32767, 32767);
		push_rect(CMD_BURN, 1'b1, 5, -3, 20, 17);                 // fractional corners
		push_rect(CMD_TEST, 1'b1, 16, 16, 17, 17);
		push_rect(CMD_TEST, 1'b1, -40, -40, -20, -20);
		push_rect(CMD_BURN, 1'b1, 512, 0, 600, 100);              // touching each edge
		push_rect(CMD_BURN, 1'b1, -600, 0, -512, 100);
		push_rect(CMD_BURN, 1'b1, 0, 512, 100, 600);
		push_rect(CMD_BURN, 1'b1, 0, -600, 100, -512);
		push_rect(CMD_TEST, 1'b0, 511, -512, 700, 511);           // one count over the edge
		push_rect(CMD_BURN, 1'b1, 100, 100, 50, 200);             // inverted
		push_rect(CMD_BURN, 1'b1, 32, 32, 32, 48);                // covers no cell
		push_rect(CMD_TEST, 1'b0, 32, 32, 32, 48);
		push_rect(CMD_BURN, 1'b1, -32768, -32768, 32767, 32767);  // whole map, clamped
		push_rect(CMD_TEST, 1'b0, -32768, -32768, 32767, 32767);
		push_rect(CMD_TEST, 1'b1, -512, -512, -511, -511);
		push_rect(CMD_BURN, 1'b0, -1, -1, 1, 1);
		push_rect(CMD_TEST, 1'b0, -17, -17, -16, -16);
		push_rect(CMD_TEST, 1'b0, 0, 0, 1, 1);
		push_rect(CMD_TEST, 1'b1, 32767, 32767, -32768, -32768);
		push_rect(CMD_BURN, 1'b0, -32768, -32768, 32767, 32767);
		push_rect(CMD_TEST, 1'b1, -32768, -32768, 32767, 32767);
		wait_drained();

		run_random(0, 0, 106);

		configure_centre(REG_CENTRE_X, 16'sh7fff);
		configure_centre(REG_CENTRE_Y, 16'sh8000);
		run_random(84, 0, 106);

		configure_centre(REG_CENTRE_X, 16'sh8000);
		configure_centre(REG_CENTRE_Y, 16'sh7fff);
		run_random(0, 84, 106);

		configure_centre(REG_CENTRE_X, 16'($urandom_range(1600) - 800));
		configure_centre(REG_CENTRE_Y, 16'($urandom_range(1600) - 800));
		run_random(24, 24, 106);

		configure_centre(REG_CENTRE_X, 16'($urandom));
		configure_centre(REG_CENTRE_Y, 16'sh0000);
		run_random(0, 0, 106);

		// let any late result show up
		repeat (GH + 8) @(posedge clk);
		if (expected_hits.size() != 0) begin
			report_failure($sformatf("%0d results never arrived", expected_hits.size()));
		end

		$display("covered %0d rectangles (%0d tests, %0d found, %0d off the map)",
				items_accepted, test_count, hit_count, off_map_count);
		$display("over %0d centre register writes, %0d errors, %0d cycles",
				centre_writes, errors, cycles);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/bmrf_pkg.sv
hw/rtl/bmrf_grid_mem.sv
hw/rtl/bmrf_rect_map.sv
hw/rtl/bitmap_rect_fill_and_test_top.sv
sim/testbench.sv
